/* rtl/mcpz_pkg.sv */
// Package for the matrix chain product block: sizes, codes, state type and
// the structs passed between the sequencer, the MAC datapath and the stores.
// No dependencies.
package mcpz_pkg;

  localparam int DIM       = 32;
  localparam int MAX_CHAIN = 64;

  localparam int IW    = $clog2(DIM);
  localparam int AW    = $clog2(DIM * DIM);
  localparam int MCW   = $clog2(MAX_CHAIN);
  localparam int ZW    = $clog2(DIM * DIM + 1);
  localparam int EW    = 32;
  localparam int ACC_W = 2 * EW + IW;
  localparam int CLW   = 7;

  localparam int STAGE_W     = 6;
  localparam int ZERO_W      = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_READ    = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [CLW-1:0] CHAIN_LEN_RESET = 7'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_MAC,
    ST_DRAIN,
    ST_COPY,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic          re;
    logic [IW-1:0] raddr;
  } rb_req_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_issue_t;

  typedef struct packed {
    logic          valid;
    logic [EW-1:0] value;
    logic          clip;
  } mac_res_t;

  typedef struct packed {
    logic               kind;
    logic [STAGE_W-1:0] stage;
    logic [ZERO_W-1:0]  zeros;
    logic               done;
    logic               sat;
    logic [EW-1:0]      element;
  } out_word_t;

endpackage

/* rtl/mcpz_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// Read data holds while no read is enabled. No dependencies.
module mcpz_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mcpz_mac.sv */
// Multiply-accumulate datapath: registered 32x32 product, wide accumulator,
// round to nearest and saturate to Q2.30. Depends on mcpz_pkg.
module mcpz_mac (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcpz_pkg::mac_issue_t            issue,
  input  logic signed [mcpz_pkg::EW-1:0]  a,
  input  logic signed [mcpz_pkg::EW-1:0]  b,
  output mcpz_pkg::mac_res_t              res
);

  localparam int ACC_W = mcpz_pkg::ACC_W;
  localparam int EW    = mcpz_pkg::EW;
  localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-30){1'b0}}, 1'b1, 29'b0};

  logic                      v0_r, f0_r, l0_r;
  logic                      v1_r, f1_r, l1_r;
  logic                      done_r;
  logic                      res_v_r;
  logic signed [2*EW-1:0]    p_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [EW-1:0]             res_r;
  logic                      clip_r;

  logic signed [ACC_W-1:0]   rnd;
  logic signed [ACC_W-1:0]   sh;
  logic                      in_range;
  logic [EW-1:0]             sat_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      done_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      v0_r    <= issue.valid;
      v1_r    <= v0_r;
      done_r  <= v1_r & l1_r;
      res_v_r <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    f0_r <= issue.first;
    l0_r <= issue.last;
    f1_r <= f0_r;
    l1_r <= l0_r;
    p_r  <= a * b;
    if (v1_r) begin
      acc_r <= f1_r ? ACC_W'(p_r) : acc_r + ACC_W'(p_r);
    end
    res_r  <= in_range ? sh[EW-1:0] : sat_val;
    clip_r <= ~in_range;
  end

  always_comb begin
    rnd      = acc_r + HALF;
    sh       = rnd >>> 30;
    in_range = (&sh[ACC_W-1:EW-1]) | ~(|sh[ACC_W-1:EW-1]);
    sat_val  = sh[ACC_W-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
  end

  assign res.valid = res_v_r;
  assign res.value = res_r;
  assign res.clip  = clip_r;

endmodule

/* rtl/mcpz_seq.sv */
// Sequencer: load and read commands, chain counters, and the row-by-row
// multiply schedule over the product, operand and row stores.
// Depends on mcpz_pkg.
module mcpz_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic signed [mcpz_pkg::EW-1:0]  in_elem,
  input  logic [4:0]                      in_row,
  input  logic [4:0]                      in_col,
  input  logic [mcpz_pkg::CLW-1:0]        chain_len,
  input  logic                            out_free,
  input  logic [mcpz_pkg::EW-1:0]         prod_rdata,
  input  logic [mcpz_pkg::EW-1:0]         rb_rdata,
  input  mcpz_pkg::mac_res_t              mac_res,
  output mcpz_pkg::mem_req_t              prod_req,
  output mcpz_pkg::mem_req_t              opnd_req,
  output mcpz_pkg::rb_req_t               rb_req,
  output mcpz_pkg::mac_issue_t            issue,
  output logic                            out_load,
  output mcpz_pkg::out_word_t             out_word
);

  localparam int DIM = mcpz_pkg::DIM;
  localparam int IW  = mcpz_pkg::IW;
  localparam int AW  = mcpz_pkg::AW;
  localparam int MCW = mcpz_pkg::MCW;
  localparam int ZW  = mcpz_pkg::ZW;

  mcpz_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]  ec_r, ec_nxt;
  logic [MCW-1:0] mc_r, mc_nxt;
  logic [IW-1:0]  i_r, i_nxt;
  logic [IW-1:0]  j_r, j_nxt;
  logic [IW-1:0]  k_r, k_nxt;
  logic [IW-1:0]  wcol_r, wcol_nxt;
  logic [IW-1:0]  cp_r, cp_nxt;
  logic           cpv_r, cpv_nxt;
  logic [AW-1:0]  cpa_r, cpa_nxt;
  logic [ZW-1:0]  zeros_r, zeros_nxt;
  logic           sat_r, sat_nxt;
  logic [MCW-1:0] stage_r, stage_nxt;
  logic           done_r, done_nxt;
  logic           oob_r, oob_nxt;

  logic           accept;
  logic           last_elem;
  logic           last_m;
  logic [31:0]    len_eff;
  logic           rd_in_range;
  logic [AW-1:0]  rd_addr;

  always_comb begin
    accept      = in_valid && (state_r == mcpz_pkg::ST_IDLE);
    last_elem   = (ec_r == AW'(DIM * DIM - 1));
    if (chain_len == '0) begin
      len_eff = 32'd1;
    end else if (32'(chain_len) > 32'(mcpz_pkg::MAX_CHAIN)) begin
      len_eff = 32'(mcpz_pkg::MAX_CHAIN);
    end else begin
      len_eff = 32'(chain_len);
    end
    last_m      = (32'(mc_r) + 32'd1) >= len_eff;
    rd_in_range = (32'(in_row) < 32'(DIM)) && (32'(in_col) < 32'(DIM));
    rd_addr     = AW'(32'(in_row) * 32'(DIM) + 32'(in_col));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcpz_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == mcpz_pkg::CMD_READ) begin
            state_nxt = mcpz_pkg::ST_RD_OUT;
          end else if (last_elem && (mc_r != '0)) begin
            state_nxt = mcpz_pkg::ST_MAC;
          end
        end
      end
      mcpz_pkg::ST_RD_OUT: begin
        if (out_free) state_nxt = mcpz_pkg::ST_IDLE;
      end
      mcpz_pkg::ST_MAC: begin
        if ((k_r == IW'(DIM - 1)) && (j_r == IW'(DIM - 1))) state_nxt = mcpz_pkg::ST_DRAIN;
      end
      mcpz_pkg::ST_DRAIN: begin
        if (mac_res.valid && (wcol_r == IW'(DIM - 1))) state_nxt = mcpz_pkg::ST_COPY;
      end
      mcpz_pkg::ST_COPY: begin
        if (cp_r == IW'(DIM - 1)) begin
          state_nxt = (i_r == IW'(DIM - 1)) ? mcpz_pkg::ST_REPORT : mcpz_pkg::ST_MAC;
        end
      end
      mcpz_pkg::ST_REPORT: begin
        if (out_free) state_nxt = mcpz_pkg::ST_IDLE;
      end
      default: state_nxt = mcpz_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ec_nxt    = ec_r;
    mc_nxt    = mc_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    wcol_nxt  = wcol_r;
    cp_nxt    = cp_r;
    cpv_nxt   = 1'b0;
    cpa_nxt   = cpa_r;
    zeros_nxt = zeros_r;
    sat_nxt   = sat_r;
    stage_nxt = stage_r;
    done_nxt  = done_r;
    oob_nxt   = oob_r;
    prod_req  = '0;
    opnd_req  = '0;
    rb_req    = '0;
    issue     = '0;
    out_load  = 1'b0;
    out_word  = '0;
    in_ready  = (state_r == mcpz_pkg::ST_IDLE);

    case (state_r)
      mcpz_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == mcpz_pkg::CMD_READ) begin
            prod_req.re    = 1'b1;
            prod_req.raddr = rd_addr;
            oob_nxt        = ~rd_in_range;
          end else begin
            if (mc_r == '0) begin
              prod_req.we    = 1'b1;
              prod_req.waddr = ec_r;
              prod_req.wdata = in_elem;
            end else begin
              opnd_req.we    = 1'b1;
              opnd_req.waddr = ec_r;
              opnd_req.wdata = in_elem;
            end
            if (last_elem) begin
              ec_nxt = '0;
              mc_nxt = last_m ? '0 : mc_r + MCW'(1);
              if (mc_r != '0) begin
                stage_nxt = mc_r;
                done_nxt  = last_m;
                zeros_nxt = '0;
                sat_nxt   = 1'b0;
                i_nxt     = '0;
                j_nxt     = '0;
                k_nxt     = '0;
                wcol_nxt  = '0;
                cp_nxt    = '0;
              end
            end else begin
              ec_nxt = ec_r + AW'(1);
            end
          end
        end
      end
      mcpz_pkg::ST_RD_OUT: begin
        out_load         = out_free;
        out_word.kind    = mcpz_pkg::KIND_READ;
        out_word.element = oob_r ? '0 : prod_rdata;
      end
      mcpz_pkg::ST_MAC: begin
        prod_req.re    = 1'b1;
        prod_req.raddr = AW'(32'(i_r) * 32'(DIM) + 32'(k_r));
        opnd_req.re    = 1'b1;
        opnd_req.raddr = AW'(32'(k_r) * 32'(DIM) + 32'(j_r));
        issue.valid    = 1'b1;
        issue.first    = (k_r == '0);
        issue.last     = (k_r == IW'(DIM - 1));
        if (k_r == IW'(DIM - 1)) begin
          k_nxt = '0;
          j_nxt = (j_r == IW'(DIM - 1)) ? '0 : j_r + IW'(1);
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      mcpz_pkg::ST_COPY: begin
        rb_req.re    = 1'b1;
        rb_req.raddr = cp_r;
        cpv_nxt      = 1'b1;
        cpa_nxt      = AW'(32'(i_r) * 32'(DIM) + 32'(cp_r));
        if (cp_r == IW'(DIM - 1)) begin
          cp_nxt = '0;
          i_nxt  = i_r + IW'(1);
        end else begin
          cp_nxt = cp_r + IW'(1);
        end
      end
      mcpz_pkg::ST_REPORT: begin
        out_load       = out_free;
        out_word.kind  = mcpz_pkg::KIND_REPORT;
        out_word.stage = mcpz_pkg::STAGE_W'(stage_r);
        out_word.zeros = mcpz_pkg::ZERO_W'(zeros_r);
        out_word.done  = done_r;
        out_word.sat   = sat_r;
      end
      default: begin
      end
    endcase

    // finished dot products land in the row buffer
    if (mac_res.valid) begin
      rb_req.we    = 1'b1;
      rb_req.waddr = wcol_r;
      rb_req.wdata = mac_res.value;
      wcol_nxt     = (wcol_r == IW'(DIM - 1)) ? '0 : wcol_r + IW'(1);
      zeros_nxt    = zeros_r + ZW'(mac_res.value == '0);
      sat_nxt      = sat_r | mac_res.clip;
    end

    // row buffer copy-back, in the cycle after its read
    if (cpv_r) begin
      prod_req.we    = 1'b1;
      prod_req.waddr = cpa_r;
      prod_req.wdata = rb_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcpz_pkg::ST_IDLE;
      ec_r    <= '0;
      mc_r    <= '0;
      cpv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ec_r    <= ec_nxt;
      mc_r    <= mc_nxt;
      cpv_r   <= cpv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    wcol_r  <= wcol_nxt;
    cp_r    <= cp_nxt;
    cpa_r   <= cpa_nxt;
    zeros_r <= zeros_nxt;
    sat_r   <= sat_nxt;
    stage_r <= stage_nxt;
    done_r  <= done_nxt;
    oob_r   <= oob_nxt;
  end

endmodule

/* rtl/matrix_chain_product_zero_count.sv */
// Top level of the matrix chain product block: configuration register,
// output register, stores, MAC datapath and sequencer.
// Depends on mcpz_pkg, mcpz_ram, mcpz_mac and mcpz_seq.
//
// Input words: tuser = 0 loads the next element of the current matrix in
// row-major order, tuser = 1 reads one product element. Output words:
// tuser = 0 is a stage report, tuser = 1 carries read data; tlast marks the
// report of the last matrix in a chain. cfg_wr_en writes the chain length.
//
// A load goes straight into a store. A read's element is registered from the
// product store, then into the output register once the output is free; the
// input is ready again when that word is loaded. The last element of every
// matrix after the first of a chain starts a multiply: the single MAC walks
// the product row by row, one dot product per element, and after each row
// copies the row back from the row buffer. No word is taken while a
// multiply runs; the report follows it.
//
// Reset clears the element and matrix counters and sets the chain length
// to 15; the stores hold nothing meaningful until loaded. A stalled
// receiver holds the output word; input is still taken until a new
// result needs the output register.
module matrix_chain_product_zero_count (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // element_in [31:0], read_row [36:32], read_col [41:37], zero pad above
  input  logic [mcpz_pkg::IN_TDATA_W-1:0]     in_tdata,
  // command
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // stage_index [5:0], zero_total [16:6], saturated [17],
  // element_out [49:18], zero pad above
  output logic [mcpz_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // result_kind
  output logic                                out_tuser,
  // chain_done
  output logic                                out_tlast,
  input  logic                                cfg_wr_en,
  input  logic [mcpz_pkg::CLW-1:0]            cfg_wr_data
);

  localparam int DIM = mcpz_pkg::DIM;
  localparam int EW  = mcpz_pkg::EW;

  logic [mcpz_pkg::CLW-1:0] chain_len_r, chain_len_nxt;
  logic                     out_valid_r, out_valid_nxt;
  mcpz_pkg::out_word_t      out_word_r, out_word_nxt;

  logic                     out_free;
  logic                     out_load;
  mcpz_pkg::out_word_t      seq_word;
  mcpz_pkg::mem_req_t       prod_req;
  mcpz_pkg::mem_req_t       opnd_req;
  mcpz_pkg::rb_req_t        rb_req;
  mcpz_pkg::mac_issue_t     issue;
  mcpz_pkg::mac_res_t       mac_res;
  logic [EW-1:0]            prod_rdata;
  logic [EW-1:0]            opnd_rdata;
  logic [EW-1:0]            rb_rdata;

  assign out_free = ~out_valid_r | out_tready;

  always_comb begin
    chain_len_nxt = cfg_wr_en ? cfg_wr_data : chain_len_r;
    out_word_nxt  = out_load ? seq_word : out_word_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_len_r <= mcpz_pkg::CHAIN_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      chain_len_r <= chain_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  mcpz_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_elem    (in_tdata[31:0]),
    .in_row     (in_tdata[36:32]),
    .in_col     (in_tdata[41:37]),
    .chain_len  (chain_len_r),
    .out_free   (out_free),
    .prod_rdata (prod_rdata),
    .rb_rdata   (rb_rdata),
    .mac_res    (mac_res),
    .prod_req   (prod_req),
    .opnd_req   (opnd_req),
    .rb_req     (rb_req),
    .issue      (issue),
    .out_load   (out_load),
    .out_word   (seq_word)
  );

  mcpz_ram #(.DEPTH(DIM * DIM), .WIDTH(EW)) u_prod_ram (
    .clk   (clk),
    .we    (prod_req.we),
    .waddr (prod_req.waddr),
    .wdata (prod_req.wdata),
    .re    (prod_req.re),
    .raddr (prod_req.raddr),
    .rdata (prod_rdata)
  );

  mcpz_ram #(.DEPTH(DIM * DIM), .WIDTH(EW)) u_opnd_ram (
    .clk   (clk),
    .we    (opnd_req.we),
    .waddr (opnd_req.waddr),
    .wdata (opnd_req.wdata),
    .re    (opnd_req.re),
    .raddr (opnd_req.raddr),
    .rdata (opnd_rdata)
  );

  mcpz_ram #(.DEPTH(DIM), .WIDTH(EW)) u_row_ram (
    .clk   (clk),
    .we    (rb_req.we),
    .waddr (rb_req.waddr),
    .wdata (rb_req.wdata),
    .re    (rb_req.re),
    .raddr (rb_req.raddr),
    .rdata (rb_rdata)
  );

  mcpz_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .a     (prod_rdata),
    .b     (opnd_rdata),
    .res   (mac_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_word_r.kind;
  assign out_tlast  = out_word_r.done;
  assign out_tdata  = {6'b0, out_word_r.element, out_word_r.sat,
                       out_word_r.zeros, out_word_r.stage};

endmodule

/* rtl/mcpz_chk.sv */
// Port-level checker for the matrix chain product block, bound to the top.
// Depends on mcpz_pkg and matrix_chain_product_zero_count.
module mcpz_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mcpz_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_read_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == mcpz_pkg::KIND_READ) |-> (out_tdata[17:0] == 18'd0) && !out_tlast)
    else $error("read word carries report fields");

  a_report_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == mcpz_pkg::KIND_REPORT) |->
      (out_tdata[49:18] == 32'd0) && (out_tdata[5:0] != 6'd0))
    else $error("malformed stage report");

  a_read_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == mcpz_pkg::CMD_READ) |=> ##1 out_tvalid)
    else $error("read not answered");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind matrix_chain_product_zero_count mcpz_chk u_chk (.*);
